FILE: design/tkht_pkg.sv
// Package: shared types, constants and status codes for the two-key hash table.
`default_nettype none
package tkht_pkg;
  localparam int TableDepth = 256;
  localparam int KeyWidth   = 32;
  localparam int DataWidth  = 32;
  localparam logic [7:0] StrideReset = 8'd133;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_PRESENT      = 3'd1,
    ST_FULL         = 3'd2,
    ST_FOUND        = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_DELETED      = 3'd5,
    ST_NONE_DELETED = 3'd6,
    ST_RESERVED     = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] data_out;
    logic [8:0]  removed_count;
    logic [8:0]  occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_CHECK,
    BK_DONE
  } back_state_t;
endpackage
`default_nettype wire

FILE: design/two_key_open_address_hash_table_unit.sv
// Top level: two-key open-addressed hash table with decoupled front and back ends.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  in      | in_valid / in_stall | in_item  (opcode, keys, data)
//  out     | out_valid/out_stall | out_item (status, slot, ...)
//  cfg     | cfg_we              | cfg_data (probe_stride)
//
// Each probe is a registered memory read followed by a compare/write, and
// the back end finishes one transaction before it takes another.
// After reset the back end clears key_a in every slot, during which no
// transaction completes. A stalled result holds the back end; the front end
// keeps accepting until its two-entry queue and its stage-1 register are full.
`default_nettype none
module two_key_open_address_hash_table_unit #(
  parameter int TABLE_DEPTH = tkht_pkg::TableDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tkht_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tkht_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic [7:0] stride;
  logic       q_valid, q_pop, q_reserved;
  logic [1:0] q_opcode;
  logic [31:0] q_key_a, q_key_b, q_data;
  logic [AW-1:0] q_home;

  always_ff @(posedge clk) begin
    if (rst)         stride <= tkht_pkg::StrideReset;
    else if (cfg_we) stride <= cfg_data;
  end

  tkht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .opcode(in_item.opcode), .key_a(in_item.key_a), .key_b(in_item.key_b),
    .data_in(in_item.data_in),
    .q_valid, .q_pop, .q_opcode, .q_key_a, .q_key_b, .q_data, .q_home, .q_reserved
  );

  tkht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .stride,
    .q_valid, .q_pop, .q_opcode, .q_key_a, .q_key_b, .q_data, .q_home, .q_reserved,
    .out_valid, .out_stall, .out_item
  );
endmodule
`default_nettype wire

FILE: design/tkht_front.sv
// Front end: accepts transactions, computes home slot, queues work for the back end.
`default_nettype none
module tkht_front #(
  parameter int TABLE_DEPTH = tkht_pkg::TableDepth,
  parameter int KEY_WIDTH   = tkht_pkg::KeyWidth,
  parameter int DATA_WIDTH  = tkht_pkg::DataWidth,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [KEY_WIDTH-1:0]  key_a,
  input  wire logic [KEY_WIDTH-1:0]  key_b,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output logic [1:0]                 q_opcode,
  output logic [KEY_WIDTH-1:0]       q_key_a,
  output logic [KEY_WIDTH-1:0]       q_key_b,
  output logic [DATA_WIDTH-1:0]      q_data,
  output logic [AW-1:0]              q_home,
  output logic                       q_reserved
);
  // stage 1: registered accepted item; stage 2: two-entry queue
  logic                  s1_valid;
  logic [1:0]            s1_op;
  logic [KEY_WIDTH-1:0]  s1_ka, s1_kb, s1_prod;
  logic [DATA_WIDTH-1:0] s1_data;
  logic [KEY_WIDTH-1:0]  kb_eff;

  logic [1:0]            fq_op   [2];
  logic [KEY_WIDTH-1:0]  fq_ka   [2];
  logic [KEY_WIDTH-1:0]  fq_kb   [2];
  logic [DATA_WIDTH-1:0] fq_data [2];
  logic [AW-1:0]         fq_home [2];
  logic                  fq_res  [2];
  logic [1:0]            cnt;
  logic                  rd_ptr, wr_ptr;
  logic                  push, s1_free;

  assign kb_eff  = (key_b == '0) ? KEY_WIDTH'(1) : key_b;
  assign push    = s1_valid && (cnt != 2'd2);
  assign s1_free = !s1_valid || push;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_op   <= opcode;
      s1_ka   <= key_a;
      s1_kb   <= key_b;
      s1_data <= data_in;
      s1_prod <= KEY_WIDTH'(key_a * kb_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_op[wr_ptr]   <= s1_op;
      fq_ka[wr_ptr]   <= s1_ka;
      fq_kb[wr_ptr]   <= s1_kb;
      fq_data[wr_ptr] <= s1_data;
      fq_home[wr_ptr] <= s1_prod[AW-1:0];
      fq_res[wr_ptr]  <= (s1_ka == '0) || (s1_op == tkht_pkg::OP_UNUSED);
    end
  end

  assign q_valid    = cnt != 2'd0;
  assign q_opcode   = fq_op[rd_ptr];
  assign q_key_a    = fq_ka[rd_ptr];
  assign q_key_b    = fq_kb[rd_ptr];
  assign q_data     = fq_data[rd_ptr];
  assign q_home     = fq_home[rd_ptr];
  assign q_reserved = fq_res[rd_ptr];
endmodule
`default_nettype wire

FILE: design/tkht_back.sv
// Back end: probe sequencer over the slot memories, builds one result per transaction.
`default_nettype none
module tkht_back #(
  parameter int TABLE_DEPTH = tkht_pkg::TableDepth,
  parameter int KEY_WIDTH   = tkht_pkg::KeyWidth,
  parameter int DATA_WIDTH  = tkht_pkg::DataWidth,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = AW + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            stride,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire logic [1:0]            q_opcode,
  input  wire logic [KEY_WIDTH-1:0]  q_key_a,
  input  wire logic [KEY_WIDTH-1:0]  q_key_b,
  input  wire logic [DATA_WIDTH-1:0] q_data,
  input  wire logic [AW-1:0]         q_home,
  input  wire logic                  q_reserved,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tkht_pkg::out_item_t        out_item
);
  tkht_pkg::back_state_t state, state_next;

  logic [KEY_WIDTH-1:0]  mem_ka [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]  mem_kb [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] mem_d  [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]  rd_ka, rd_kb;
  logic [DATA_WIDTH-1:0] rd_d;

  logic [AW-1:0]         clr_addr, pos, start, pos_step;
  logic [CW-1:0]         nprobe, removed, occ;
  logic [1:0]            op;
  logic [KEY_WIDTH-1:0]  ka, kb;
  logic [DATA_WIDTH-1:0] din;
  logic [2:0]            st;
  logic [AW-1:0]         hit_slot;
  logic [DATA_WIDTH-1:0] dout;

  logic is_empty, is_match, finish, last_probe;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [KEY_WIDTH-1:0] wr_ka;
  logic wr_full;

  assign pos_step   = AW'((CW)'(pos) + (CW)'(stride));
  assign is_empty   = rd_ka == '0;
  assign is_match   = (rd_ka == ka) && (rd_kb == kb);
  assign last_probe = (pos_step == start) || (nprobe == CW'(TABLE_DEPTH - 1));
  assign finish = last_probe
               || ((op == tkht_pkg::OP_INSERT) && (is_empty || is_match))
               || ((op == tkht_pkg::OP_LOOKUP) && is_match);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tkht_pkg::BK_CLEAR: if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = tkht_pkg::BK_IDLE;
      tkht_pkg::BK_IDLE: if (q_valid) state_next = q_reserved ? tkht_pkg::BK_DONE
                                                               : tkht_pkg::BK_READ;
      tkht_pkg::BK_READ:  state_next = tkht_pkg::BK_CHECK;
      tkht_pkg::BK_CHECK: state_next = finish ? tkht_pkg::BK_DONE : tkht_pkg::BK_READ;
      tkht_pkg::BK_DONE:  if (!out_stall) state_next = tkht_pkg::BK_IDLE;
      default: state_next = tkht_pkg::BK_IDLE;
    endcase
  end

  // outputs and memory write control
  always_comb begin
    q_pop   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_ka   = ka;
    wr_full = 1'b0;
    unique case (state)
      tkht_pkg::BK_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_addr; wr_ka = '0;
      end
      tkht_pkg::BK_IDLE: q_pop = q_valid;
      tkht_pkg::BK_CHECK: begin
        if (op == tkht_pkg::OP_INSERT && is_empty) begin
          wr_en = 1'b1; wr_full = 1'b1;
        end else if (op == tkht_pkg::OP_DELETE && is_match) begin
          wr_en = 1'b1; wr_ka = '0;
        end
      end
      default: ;
    endcase
  end
  assign out_valid = state == tkht_pkg::BK_DONE;

  always_ff @(posedge clk) begin
    if (rst) state <= tkht_pkg::BK_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_ka[wr_addr] <= wr_ka;
    if (wr_full) begin
      mem_kb[wr_addr] <= kb;
      mem_d[wr_addr]  <= din;
    end
    rd_ka <= mem_ka[pos];
    rd_kb <= mem_kb[pos];
    rd_d  <= mem_d[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      occ      <= '0;
    end else begin
      if (state == tkht_pkg::BK_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == tkht_pkg::BK_CHECK) begin
        if (op == tkht_pkg::OP_INSERT && is_empty && occ != CW'(TABLE_DEPTH))
          occ <= occ + CW'(1);
        else if (op == tkht_pkg::OP_DELETE && is_match && occ != '0)
          occ <= occ - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tkht_pkg::BK_IDLE: if (q_valid) begin
        op <= q_opcode; ka <= q_key_a; kb <= q_key_b; din <= q_data;
        pos <= q_home; start <= q_home; nprobe <= '0; removed <= '0;
        hit_slot <= '0; dout <= '0;
        if (q_reserved) begin
          st <= tkht_pkg::ST_RESERVED;
        end else begin
          unique case (q_opcode)
            tkht_pkg::OP_INSERT: st <= tkht_pkg::ST_FULL;
            tkht_pkg::OP_LOOKUP: st <= tkht_pkg::ST_NOT_FOUND;
            default:             st <= tkht_pkg::ST_NONE_DELETED;
          endcase
        end
      end
      tkht_pkg::BK_CHECK: begin
        pos    <= pos_step;
        nprobe <= nprobe + CW'(1);
        case (op)
          tkht_pkg::OP_INSERT:
            if (is_empty) begin
              st <= tkht_pkg::ST_INSERTED; hit_slot <= pos;
            end else if (is_match) begin
              st <= tkht_pkg::ST_PRESENT; hit_slot <= pos;
            end
          tkht_pkg::OP_LOOKUP:
            if (is_match) begin
              st <= tkht_pkg::ST_FOUND; hit_slot <= pos; dout <= rd_d;
            end
          default:
            if (is_match) begin
              st <= tkht_pkg::ST_DELETED; removed <= removed + CW'(1);
            end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item.status        = st;
    out_item.slot          = 8'(hit_slot);
    out_item.data_out      = 32'(dout);
    out_item.removed_count = 9'(removed);
    out_item.occupancy     = 9'(occ);
  end
endmodule
`default_nettype wire

FILE: dv/tkht_checker.sv
// Checker: watches the request/response channels and predicts hash table results.
`default_nettype none
module tkht_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire tkht_pkg::in_item_t  in_item,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire tkht_pkg::out_item_t out_item,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data,
  output int                       errors,
  output int                       pending
);
  logic [31:0] tbl_ka [tkht_pkg::TableDepth];
  logic [31:0] tbl_kb [tkht_pkg::TableDepth];
  logic [31:0] tbl_data [tkht_pkg::TableDepth];
  logic [8:0]  held;
  logic [7:0]  stride;
  tkht_pkg::out_item_t expected_q[$];

  function automatic logic [7:0] home_of(logic [31:0] ka, logic [31:0] kb);
    logic [31:0] prod;
    prod = ka * ((kb == 0) ? 32'd1 : kb);
    return prod[7:0];
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic tkht_pkg::out_item_t table_op(tkht_pkg::in_item_t t);
    tkht_pkg::out_item_t r;
    logic [7:0] start, pos;
    int n;
    bit done;
    r = '0;
    r.status = tkht_pkg::ST_RESERVED;
    if (t.key_a != 0 && t.opcode != tkht_pkg::OP_UNUSED) begin
      start = home_of(t.key_a, t.key_b);
      pos = start;
      n = 0;
      done = 0;
      if (t.opcode == tkht_pkg::OP_INSERT) r.status = tkht_pkg::ST_FULL;
      else if (t.opcode == tkht_pkg::OP_LOOKUP) r.status = tkht_pkg::ST_NOT_FOUND;
      do begin
        if (t.opcode == tkht_pkg::OP_INSERT) begin
          if (tbl_ka[pos] == 0) begin
            tbl_ka[pos] = t.key_a;
            tbl_kb[pos] = t.key_b;
            tbl_data[pos] = t.data_in;
            if (held < tkht_pkg::TableDepth) held++;
            r.status = tkht_pkg::ST_INSERTED;
            r.slot = pos;
            done = 1;
          end else if (tbl_ka[pos] == t.key_a && tbl_kb[pos] == t.key_b) begin
            r.status = tkht_pkg::ST_PRESENT;
            r.slot = pos;
            done = 1;
          end
        end else if (t.opcode == tkht_pkg::OP_LOOKUP) begin
          if (tbl_ka[pos] == t.key_a && tbl_kb[pos] == t.key_b) begin
            r.status = tkht_pkg::ST_FOUND;
            r.slot = pos;
            r.data_out = tbl_data[pos];
            done = 1;
          end
        end else if (tbl_ka[pos] == t.key_a && tbl_kb[pos] == t.key_b) begin
          tbl_ka[pos] = 0;
          if (held > 0) held--;
          r.removed_count++;
        end
        pos = pos + stride;
        n++;
      end while (!done && pos != start && n < tkht_pkg::TableDepth);
      if (t.opcode == tkht_pkg::OP_DELETE)
        r.status = (r.removed_count != 0) ? tkht_pkg::ST_DELETED : tkht_pkg::ST_NONE_DELETED;
    end
    r.occupancy = held;
    return r;
  endfunction

  always @(posedge clk) begin
    tkht_pkg::out_item_t exp_r;
    if (rst) begin
      for (int i = 0; i < tkht_pkg::TableDepth; i++) begin
        tbl_ka[i] = '0;
        tbl_kb[i] = '0;
        tbl_data[i] = '0;
      end
      held = '0;
      stride = tkht_pkg::StrideReset;
      expected_q = {};
      errors = 0;
    end else begin
      if (cfg_we) stride = cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(table_op(in_item));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.status !== out_item.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_item.status);
            errors++;
          end
          if (exp_r.slot !== out_item.slot) begin
            $display("%0t: slot exp %0d got %0d", $time, exp_r.slot, out_item.slot);
            errors++;
          end
          if (exp_r.data_out !== out_item.data_out) begin
            $display("%0t: data_out exp %h got %h", $time, exp_r.data_out, out_item.data_out);
            errors++;
          end
          if (exp_r.removed_count !== out_item.removed_count) begin
            $display("%0t: removed_count exp %0d got %0d", $time,
                     exp_r.removed_count, out_item.removed_count);
            errors++;
          end
          if (exp_r.occupancy !== out_item.occupancy) begin
            $display("%0t: occupancy exp %0d got %0d", $time,
                     exp_r.occupancy, out_item.occupancy);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule
`default_nettype wire

FILE: dv/tb_two_key_open_address_hash_table_unit.sv
// Testbench top: stimulus, idling and verdict for the two-key hash table unit.
`default_nettype none
module tb_two_key_open_address_hash_table_unit;
  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  tkht_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  tkht_pkg::out_item_t out_item;
  logic      cfg_we = 0;
  logic [7:0] cfg_data = '0;
  int        errors;
  int        pending;

  // Small key pools so that inserts collide, repeat and get deleted again.
  logic [31:0] pool_a [8];
  logic [31:0] pool_b [8];

  always #4 clk = ~clk;

  two_key_open_address_hash_table_unit dut (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item, .cfg_we, .cfg_data
  );

  tkht_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
    .out_item, .cfg_we, .cfg_data, .errors, .pending
  );

  // No gap half the time, otherwise mostly a short one and now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 600);
  endfunction

  // Receiver side: random stall, changed at the falling edge only.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g != 0) begin
        out_stall <= 1;
        repeat (g) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Present one transaction and hold it until accepted. in_stall only moves
  // at the rising edge, so its value at the falling edge holds for the next one.
  task automatic send(logic [1:0] op, logic [31:0] ka, logic [31:0] kb, logic [31:0] d);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_item <= '{opcode: op, key_a: ka, key_b: kb, data_in: d};
    in_valid <= 1;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until all results are in, then allow for a worst-case probe walk.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (2 * tkht_pkg::TableDepth + 20) @(negedge clk);
  endtask

  task automatic set_stride(logic [7:0] s);
    drain();
    cfg_data <= s;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    int p;
    logic [1:0] op;
    logic [31:0] ka, kb;
    p = $urandom_range(0, 99);
    op = (p < 45) ? tkht_pkg::OP_INSERT : (p < 70) ? tkht_pkg::OP_LOOKUP :
         (p < 95) ? tkht_pkg::OP_DELETE : tkht_pkg::OP_UNUSED;
    if ($urandom_range(0, 9) < 8) begin
      ka = pool_a[$urandom_range(0, 7)];
      kb = pool_b[$urandom_range(0, 7)];
    end else begin
      ka = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
      kb = $urandom;
    end
    send(op, ka, kb, $urandom);
  endtask

  initial begin
    logic [7:0] strides [6];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    for (int i = 0; i < 8; i++) begin
      pool_a[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom | 32'd1;
      pool_b[i] = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
    end

    // Directed: field extremes, every opcode, reserved key, unused opcode.
    send(tkht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(tkht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send(tkht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send(tkht_pkg::OP_INSERT, 32'd1, 32'd0, 32'hA5A5_5A5A);
    send(tkht_pkg::OP_INSERT, 32'd1, 32'd1, 32'h5A5A_A5A5);
    send(tkht_pkg::OP_LOOKUP, 32'd1, 32'd0, 32'h0);
    send(tkht_pkg::OP_LOOKUP, 32'd2, 32'd7, 32'h0);
    send(tkht_pkg::OP_INSERT, 32'd0, 32'd5, 32'h1234);
    send(tkht_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'h0);
    send(tkht_pkg::OP_UNUSED, 32'd9, 32'd9, 32'hFFFF_FFFF);
    send(tkht_pkg::OP_DELETE, 32'd1, 32'd0, 32'h0);
    send(tkht_pkg::OP_DELETE, 32'd1, 32'd0, 32'h0);
    // Duplicates: after a delete, the re-insert lands before the old copy.
    send(tkht_pkg::OP_INSERT, 32'd3, 32'd256, 32'h11);
    send(tkht_pkg::OP_INSERT, 32'd5, 32'd256, 32'h22);
    send(tkht_pkg::OP_DELETE, 32'd3, 32'd256, 32'h0);
    send(tkht_pkg::OP_INSERT, 32'd5, 32'd256, 32'h33);
    send(tkht_pkg::OP_LOOKUP, 32'd5, 32'd256, 32'h0);
    send(tkht_pkg::OP_DELETE, 32'd5, 32'd256, 32'h0);

    // Stride zero probes only the home slot: fill it, then see table full.
    set_stride(8'd0);
    send(tkht_pkg::OP_INSERT, 32'd4, 32'd256, 32'h44);
    send(tkht_pkg::OP_INSERT, 32'd6, 32'd256, 32'h66);
    send(tkht_pkg::OP_DELETE, 32'd4, 32'd256, 32'h0);

    // Fill the whole table with stride 1, then hit full and empty it again.
    set_stride(8'd1);
    for (int i = 0; i < tkht_pkg::TableDepth; i++)
      send(tkht_pkg::OP_INSERT, 32'h100 + i, 32'd1, i);
    send(tkht_pkg::OP_INSERT, 32'h7777, 32'd3, 32'h0);
    send(tkht_pkg::OP_LOOKUP, 32'h7777, 32'd3, 32'h0);
    send(tkht_pkg::OP_INSERT, 32'h100, 32'd1, 32'h0);
    for (int i = 0; i < tkht_pkg::TableDepth; i++)
      send(tkht_pkg::OP_DELETE, 32'h100 + i, 32'd1, 32'h0);

    // Random phases across several strides, extremes included.
    strides = '{8'd255, 8'd2, 8'd128, 8'd133, 8'd1, 8'd0};
    for (int ph = 0; ph < 6; ph++) begin
      set_stride(ph == 3 ? 8'($urandom_range(1, 255)) : strides[ph]);
      for (int i = 0; i < 110; i++) random_item();
    end
    drain();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #200000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
